/* hdl/pht_pkg.sv */
// Shared types, constants and the list action function of the page hotness tracker.
`timescale 1ns / 1ps
`default_nettype none

package pht_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int COUNT_BITS = 16;
  localparam int EPOCH_BITS = 32;
  localparam int PAGE_BITS  = $clog2(NUM_PAGES);
  localparam int SHIFT_BITS = $clog2(COUNT_BITS);
  localparam int TIME_BITS  = 64;
  localparam int IP_BITS    = 64;
  localparam int THR_BITS   = 16;
  localparam int COOL_BITS  = 32;
  localparam int INDEX_BITS = 12;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // One page entry as it lies in the page store.
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [EPOCH_BITS-1:0] epoch;
    logic [TIME_BITS-1:0]  newest_time;
    logic [IP_BITS-1:0]    newest_ip;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_ENQ_HOT     = 3'd1,
    ACT_COLD_TO_HOT = 3'd2,
    ACT_ENQ_COLD    = 3'd3,
    ACT_HOT_TO_COLD = 3'd4,
    ACT_FREE_SKIP   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    LIST_NONE = 2'd0,
    LIST_HOT  = 2'd1,
    LIST_COLD = 2'd2,
    LIST_ODD  = 2'd3
  } list_e;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_HOT_LEVEL     = 1'b0,
    REG_COOL_INTERVAL = 1'b1
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load_item;
    logic                 rd_en;
    logic                 commit;
    logic                 clr_en;
    logic [PAGE_BITS-1:0] clr_addr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic action_e pick_action(input logic hot, input logic free_bit,
                                          input logic fast, input logic [1:0] list_code);
    action_e act;
    list_e   lst;
    act = ACT_NONE;
    lst = list_e'(list_code);
    if (lst == LIST_ODD) begin
      lst = LIST_NONE;
    end
    if (free_bit) begin
      act = ACT_FREE_SKIP;
    end else if (hot) begin
      if (lst != LIST_HOT && !fast) begin
        act = (lst == LIST_COLD) ? ACT_COLD_TO_HOT : ACT_ENQ_HOT;
      end
    end else begin
      if (lst != LIST_COLD && fast) begin
        act = (lst == LIST_HOT) ? ACT_HOT_TO_COLD : ACT_ENQ_COLD;
      end
    end
    return act;
  endfunction

endpackage

`default_nettype wire

/* hdl/pht_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/pht_ctrl.sv */
// Controller state machine: clearing sweep, sample accept, store read and commit.
`timescale 1ns / 1ps
`default_nettype none

module pht_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire pht_pkg::sts_t sts_i,
  output pht_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CALC  = 4'b1000
  } state_e;

  localparam logic [pht_pkg::PAGE_BITS-1:0] LAST_PAGE =
    pht_pkg::PAGE_BITS'(pht_pkg::NUM_PAGES - 1);

  state_e                        state_q, state_d;
  logic [pht_pkg::PAGE_BITS-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    state_d        = state_q;
    clr_cnt_d      = clr_cnt_q;
    in_stall_o     = 1'b1;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_PAGE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CALC;
      end
      ST_CALC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/pht_datapath.sv */
// Datapath: sample registers, page store, decay and classify logic, epoch and result registers.
`timescale 1ns / 1ps
`default_nettype none

module pht_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pht_pkg::cmd_t                    cmd_i,
  output pht_pkg::sts_t                         sts_o,
  input  wire logic [pht_pkg::THR_BITS-1:0]     hot_level_i,
  input  wire logic [pht_pkg::COOL_BITS-1:0]    cool_interval_i,
  input  wire logic [pht_pkg::INDEX_BITS-1:0]   page_index_i,
  input  wire logic [pht_pkg::TIME_BITS-1:0]    sample_time_i,
  input  wire logic [pht_pkg::IP_BITS-1:0]      sample_ip_i,
  input  wire logic [pht_pkg::TIME_BITS-1:0]    now_cycles_i,
  input  wire logic                             page_free_i,
  input  wire logic                             in_fast_tier_i,
  input  wire logic [1:0]                       current_list_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [2:0]                            action_o,
  output logic                                  is_hot_o,
  output logic [pht_pkg::COUNT_BITS-1:0]        access_count_o,
  output logic                                  newer_sample_o
);

  // Sample held while it is worked on.
  logic [pht_pkg::PAGE_BITS-1:0] page_q;
  logic [pht_pkg::TIME_BITS-1:0] time_q;
  logic [pht_pkg::IP_BITS-1:0]   ip_q;
  logic [pht_pkg::TIME_BITS-1:0] now_q;
  logic                          free_q;
  logic                          fast_q;
  logic [1:0]                    list_q;

  logic [pht_pkg::EPOCH_BITS-1:0] epoch_q, epoch_d;
  logic [pht_pkg::TIME_BITS-1:0]  last_cool_q, last_cool_d;

  logic                           out_valid_q;
  pht_pkg::action_e               action_q;
  logic                           hot_q;
  logic [pht_pkg::COUNT_BITS-1:0] count_q;
  logic                           newer_q;

  pht_pkg::entry_t                rd_entry;
  pht_pkg::entry_t                wr_entry;
  logic [pht_pkg::ENTRY_BITS-1:0] rdata;
  logic [pht_pkg::PAGE_BITS-1:0]  ram_addr;

  logic [pht_pkg::EPOCH_BITS-1:0] epoch_gap;
  logic [pht_pkg::COUNT_BITS-1:0] decayed;
  logic [pht_pkg::COUNT_BITS-1:0] bumped;
  logic                           newer;
  logic                           hot;
  logic [pht_pkg::TIME_BITS-1:0]  gap;
  logic                           advance;
  pht_pkg::action_e               action;

  assign ram_addr = cmd_i.clr_en ? cmd_i.clr_addr : page_q;
  assign rd_entry = pht_pkg::entry_t'(rdata);

  pht_ram #(
    .WIDTH (pht_pkg::ENTRY_BITS),
    .DEPTH (pht_pkg::NUM_PAGES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_en | cmd_i.commit),
    .re_i    (cmd_i.rd_en),
    .addr_i  (ram_addr),
    .wdata_i (wr_entry),
    .rdata_o (rdata)
  );

  always_comb begin
    epoch_gap = epoch_q - rd_entry.epoch;
    if (epoch_gap >= pht_pkg::EPOCH_BITS'(pht_pkg::COUNT_BITS)) begin
      decayed = '0;
    end else begin
      decayed = rd_entry.count >> epoch_gap[pht_pkg::SHIFT_BITS-1:0];
    end
    bumped  = (decayed == pht_pkg::COUNT_MAX) ? decayed : decayed + 1'b1;
    newer   = time_q > rd_entry.newest_time;
    hot     = bumped >= hot_level_i;
    action  = pht_pkg::pick_action(hot, free_q, fast_q, list_q);
    gap     = now_q - last_cool_q;
    advance = gap > {{(pht_pkg::TIME_BITS - pht_pkg::COOL_BITS){1'b0}}, cool_interval_i};

    if (cmd_i.clr_en) begin
      wr_entry = '0;
    end else begin
      wr_entry.count       = bumped;
      wr_entry.epoch       = epoch_q;
      wr_entry.newest_time = newer ? time_q : rd_entry.newest_time;
      wr_entry.newest_ip   = newer ? ip_q : rd_entry.newest_ip;
    end

    epoch_d     = epoch_q;
    last_cool_d = last_cool_q;
    if (cmd_i.commit && advance) begin
      epoch_d     = epoch_q + 1'b1;
      last_cool_d = now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      page_q <= page_index_i[pht_pkg::PAGE_BITS-1:0];
      time_q <= sample_time_i;
      ip_q   <= sample_ip_i;
      now_q  <= now_cycles_i;
      free_q <= page_free_i;
      fast_q <= in_fast_tier_i;
      list_q <= current_list_i;
    end
    if (cmd_i.commit) begin
      action_q <= action;
      hot_q    <= hot;
      count_q  <= bumped;
      newer_q  <= newer;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= '0;
      last_cool_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      epoch_q     <= epoch_d;
      last_cool_q <= last_cool_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign is_hot_o       = hot_q;
  assign access_count_o = count_q;
  assign newer_sample_o = newer_q;

endmodule

`default_nettype wire

/* hdl/page_hotness_tracker.sv */
// Top level of the page hotness tracker: configuration registers, controller and datapath.
// Flow: a taken sample beat is held in the sample registers, the page store is read into its
// registered read data, then decay and commit load the result registers, and out_valid_o is
// set. No new sample is taken before the last has committed, because of the read-modify-write
// of the page store; a result held by out_stall_i holds the next commit back. Reset: a clearing
// pass writes all 4096 page entries with in_stall_o high; the registers reset to 8, 100000000.
`timescale 1ns / 1ps
`default_nettype none

module page_hotness_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  // Sample channel.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pht_pkg::INDEX_BITS-1:0] page_index_i,
  input  wire logic [pht_pkg::TIME_BITS-1:0]  sample_time_i,
  input  wire logic [pht_pkg::IP_BITS-1:0]    sample_ip_i,
  input  wire logic [pht_pkg::TIME_BITS-1:0]  now_cycles_i,
  input  wire logic                           page_free_i,
  input  wire logic                           in_fast_tier_i,
  input  wire logic [1:0]                     current_list_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [2:0]                          action_o,
  output logic                                is_hot_o,
  output logic [pht_pkg::COUNT_BITS-1:0]      access_count_o,
  output logic                                newer_sample_o
);

  localparam logic [pht_pkg::THR_BITS-1:0]  THR_RESET  = pht_pkg::THR_BITS'(8);
  localparam logic [pht_pkg::COOL_BITS-1:0] COOL_RESET = pht_pkg::COOL_BITS'(100000000);

  logic [pht_pkg::THR_BITS-1:0]  hot_level_q;
  logic [pht_pkg::COOL_BITS-1:0] cool_interval_q;
  logic                          cfg_write;
  pht_pkg::reg_e                 reg_sel;

  pht_pkg::cmd_t cmd;
  pht_pkg::sts_t sts;

  // The port always completes in its access cycle. Registers are word aligned, so
  // only address bit two selects one; the byte offset bits are not decoded.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = pht_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_level_q     <= THR_RESET;
      cool_interval_q <= COOL_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        pht_pkg::REG_HOT_LEVEL:     hot_level_q     <= pwdata[pht_pkg::THR_BITS-1:0];
        pht_pkg::REG_COOL_INTERVAL: cool_interval_q <= pwdata[pht_pkg::COOL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pht_pkg::REG_HOT_LEVEL:
        prdata = {{(32 - pht_pkg::THR_BITS){1'b0}}, hot_level_q};
      pht_pkg::REG_COOL_INTERVAL:
        prdata = cool_interval_q;
      default:
        prdata = '0;
    endcase
  end

  // The controller sequences the clearing pass and each sample's store access; the
  // datapath holds the store, the decay arithmetic and the output register.
  pht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pht_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .hot_level_i     (hot_level_q),
    .cool_interval_i (cool_interval_q),
    .page_index_i    (page_index_i),
    .sample_time_i   (sample_time_i),
    .sample_ip_i     (sample_ip_i),
    .now_cycles_i    (now_cycles_i),
    .page_free_i     (page_free_i),
    .in_fast_tier_i  (in_fast_tier_i),
    .current_list_i  (current_list_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .is_hot_o        (is_hot_o),
    .access_count_o  (access_count_o),
    .newer_sample_o  (newer_sample_o)
  );

endmodule

`default_nettype wire
